FILE: design/hdlf_pkg.sv
// ----------------------------------------------------------------------------
// hdlf_pkg
// Shared types, character constants and helper functions for the hex dump
// line formatter: controller command/status bundles and segment codes.
// ----------------------------------------------------------------------------
package hdlf_pkg;

  // Line geometry (sixteen bytes per line, column index 0..15)
  localparam logic [3:0] LAST_COL = 4'd15;

  // ASCII characters used in the dump text
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_TILDE = 8'h7e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;

  // Configuration register indexes
  localparam logic REG_SHOW_ADDRESS = 1'b0;
  localparam logic REG_SHOW_TEXT    = 1'b1;

  // Segment of a line that the character generator produces
  typedef enum logic [2:0] {
    SEG_NL      = 3'd0,
    SEG_ADDR_HI = 3'd1,
    SEG_ADDR_LO = 3'd2,
    SEG_HEX     = 3'd3,
    SEG_PAD     = 3'd4,
    SEG_TEXT    = 3'd5
  } seg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;        // capture the input transaction
    logic       gen;         // request one chunk of characters
    logic       last;        // this chunk closes the item
    seg_t       seg;         // which segment to generate
    logic       lead_space;  // hex group preceded by the address space
    logic [2:0] pad_n;       // number of pad spaces in this chunk
    logic [1:0] row;         // text column row (four characters each)
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [3:0] col;
    logic       past_first;
    logic       show_addr;
    logic       show_text;
    logic       final_flag;
    logic       pk_ready;
  } sts_t;

  // Lowercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else begin
      c = CHAR_LC_A + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

  // Printable bytes show as themselves, all others as a dot
  function automatic logic [7:0] printable(input logic [7:0] d);
    logic [7:0] c;
    if (d >= CHAR_SPACE && d <= CHAR_TILDE) begin
      c = d;
    end else begin
      c = CHAR_DOT;
    end
    return c;
  endfunction

endpackage

FILE: design/hex_dump_line_formatter_unit.sv
// ----------------------------------------------------------------------------
// hex_dump_line_formatter_unit
// Hex dump text generator: one data byte in, ASCII dump text out, up to four
// characters per output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one data byte per transaction;
//   in_is_final marks the last byte of a dump, which pads and closes its line.
//   Output channel (out_valid / out_stall) delivers chunks of one to four
//   characters; out_run_end marks the last chunk of a byte, out_dump_end the
//   last chunk of the dump. Configuration (cfg_we / cfg_index / cfg_wdata)
//   sets show_address (index 0) and show_text (index 1); write only when idle.
//   Timing: one byte at a time. A mid-line byte is accepted, then sent as one
//   hex chunk. The first byte of a line is preceded by a newline chunk (not on
//   the first line of a dump) and two address chunks when show_address is set.
//   A closing byte adds chunks of up to four pad spaces and, when show_text is
//   set, the text column as four rows; a partial chunk left over is flushed.
//   The sequencer sends one chunk per cycle while the packer is ready.
//   Reset (rst_n low, synchronous) restores both options to 1, starts a new
//   dump at address zero and empties the output. A stalled receiver holds the
//   output register and the sequencer waits; no characters are dropped.
// ----------------------------------------------------------------------------
module hex_dump_line_formatter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_a,
  output logic [7:0] out_char_b,
  output logic [7:0] out_char_c,
  output logic [7:0] out_char_d,
  output logic [2:0] out_char_count,
  output logic       out_run_end,
  output logic       out_dump_end,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata
);

  hdlf_pkg::cmd_t cmd;
  hdlf_pkg::sts_t sts;

  // Segment sequencer
  hdlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Character generator, packer and output register
  hdlf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_data_byte   (in_data_byte),
    .in_is_final    (in_is_final),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_a     (out_char_a),
    .out_char_b     (out_char_b),
    .out_char_c     (out_char_c),
    .out_char_d     (out_char_d),
    .out_char_count (out_char_count),
    .out_run_end    (out_run_end),
    .out_dump_end   (out_dump_end)
  );

endmodule

FILE: design/hdlf_ctrl.sv
// ----------------------------------------------------------------------------
// hdlf_ctrl
// Line sequencer: walks the segments of one item (newline, address, hex group,
// pad, text column) and issues one chunk command per cycle while the datapath is ready.
// ----------------------------------------------------------------------------
module hdlf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output hdlf_pkg::cmd_t cmd,
  input  hdlf_pkg::sts_t sts
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_NL      = 7'b0000010,
    ST_ADDR_HI = 7'b0000100,
    ST_ADDR_LO = 7'b0001000,
    ST_HEX     = 7'b0010000,
    ST_PAD     = 7'b0100000,
    ST_TEXT    = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       lead_r, lead_nxt;
  logic [5:0] pad_left_r, pad_left_nxt;
  logic [1:0] row_r, row_nxt;

  logic       in_fire;
  logic       gen_fire;
  logic       closing;
  logic [3:0] col_left;
  logic [5:0] pad_full;
  logic [5:0] pad_total;
  logic [2:0] pad_now;
  logic       last;
  hdlf_pkg::seg_t seg;

  // Pad length of a closing line: three columns per missing byte, minus the
  // trailing space of the last group when the text column is off
  always_comb begin
    col_left  = hdlf_pkg::LAST_COL - sts.col;
    pad_full  = {2'b00, col_left} + {1'b0, col_left, 1'b0};
    pad_total = (col_left == 4'd0) ? 6'd0 : pad_full - {5'd0, ~sts.show_text};
    pad_now   = (pad_left_r > 6'd4) ? 3'd4 : pad_left_r[2:0];
    closing   = (sts.col == hdlf_pkg::LAST_COL) || sts.final_flag;
  end

  assign in_fire  = in_valid && (state_r == ST_IDLE);
  assign gen_fire = (state_r != ST_IDLE) && sts.pk_ready;
  assign in_stall = (state_r != ST_IDLE);

  // Segment sequencing
  always_comb begin
    state_nxt    = state_r;
    lead_nxt     = lead_r;
    pad_left_nxt = pad_left_r;
    row_nxt      = row_r;
    last         = 1'b0;
    seg          = hdlf_pkg::SEG_HEX;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          lead_nxt = (sts.col == 4'd0) && sts.show_addr;
          if (sts.col == 4'd0 && sts.past_first) begin
            state_nxt = ST_NL;
          end else if (sts.col == 4'd0 && sts.show_addr) begin
            state_nxt = ST_ADDR_HI;
          end else begin
            state_nxt = ST_HEX;
          end
        end
      end
      ST_NL: begin
        seg = hdlf_pkg::SEG_NL;
        if (gen_fire) begin
          state_nxt = lead_r ? ST_ADDR_HI : ST_HEX;
        end
      end
      ST_ADDR_HI: begin
        seg = hdlf_pkg::SEG_ADDR_HI;
        if (gen_fire) begin
          state_nxt = ST_ADDR_LO;
        end
      end
      ST_ADDR_LO: begin
        seg = hdlf_pkg::SEG_ADDR_LO;
        if (gen_fire) begin
          state_nxt = ST_HEX;
        end
      end
      ST_HEX: begin
        seg  = hdlf_pkg::SEG_HEX;
        last = !(closing && (pad_total != 6'd0 || sts.show_text));
        if (gen_fire) begin
          row_nxt      = 2'd0;
          pad_left_nxt = pad_total;
          if (closing && pad_total != 6'd0) begin
            state_nxt = ST_PAD;
          end else if (closing && sts.show_text) begin
            state_nxt = ST_TEXT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        seg  = hdlf_pkg::SEG_PAD;
        last = (pad_left_r <= 6'd4) && !sts.show_text;
        if (gen_fire) begin
          pad_left_nxt = pad_left_r - {3'd0, pad_now};
          if (pad_left_r <= 6'd4) begin
            state_nxt = sts.show_text ? ST_TEXT : ST_IDLE;
          end
        end
      end
      ST_TEXT: begin
        seg  = hdlf_pkg::SEG_TEXT;
        last = (row_r == 2'd3);
        if (gen_fire) begin
          row_nxt = row_r + 2'd1;
          if (row_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    cmd.load       = in_fire;
    cmd.gen        = (state_r != ST_IDLE);
    cmd.last       = last;
    cmd.seg        = seg;
    cmd.lead_space = lead_r;
    cmd.pad_n      = pad_now;
    cmd.row        = row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      lead_r     <= 1'b0;
      pad_left_r <= 6'd0;
      row_r      <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      lead_r     <= lead_nxt;
      pad_left_r <= pad_left_nxt;
      row_r      <= row_nxt;
    end
  end

  // Pad segment always has spaces left to send
  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD) |-> (pad_left_r != 6'd0))
    else $error("pad segment entered with no pad characters");

  // A chunk marked last always returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_fire && last) |=> (state_r == ST_IDLE))
    else $error("last chunk did not return to idle");

endmodule

FILE: design/hdlf_dp.sv
// ----------------------------------------------------------------------------
// hdlf_dp
// Datapath: line state, text buffer, configuration registers, chunk character
// generator, four-character packer and the output register.
// ----------------------------------------------------------------------------
module hdlf_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  hdlf_pkg::cmd_t cmd,
  output hdlf_pkg::sts_t sts,
  input  logic [7:0]     in_data_byte,
  input  logic           in_is_final,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_wdata,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_char_a,
  output logic [7:0]     out_char_b,
  output logic [7:0]     out_char_c,
  output logic [7:0]     out_char_d,
  output logic [2:0]     out_char_count,
  output logic           out_run_end,
  output logic           out_dump_end
);

  // Line state and configuration
  logic [27:0] line_r;
  logic [3:0]  col_r;
  logic        past_r;
  logic        show_addr_r;
  logic        show_text_r;
  logic [7:0]  byte_r;
  logic        fin_r;
  logic [3:0][7:0] text_row_r [4];

  // Packer state
  logic [7:0] hold_r [3];
  logic [7:0] hold_nxt [3];
  logic [1:0] hold_cnt_r, hold_cnt_nxt;
  logic       flush_r, flush_nxt;
  logic       flush_fin_r, flush_fin_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_chr_r [4];
  logic [7:0] out_chr_nxt [4];
  logic [2:0] out_cnt_r, out_cnt_nxt;
  logic       out_run_r, out_run_nxt;
  logic       out_dump_r, out_dump_nxt;

  logic        out_free;
  logic        pk_ready;
  logic        gen_fire;
  logic        out_load;
  logic        sp;
  logic [31:0] addr_w;
  logic [3:0][7:0] row_data;
  logic [7:0]  g [4];
  logic [2:0]  gen_n;
  logic [7:0]  w [7];
  logic [2:0]  tot;
  logic [2:0]  out_sel_cnt;

  assign out_free = !out_valid_r || !out_stall;
  assign pk_ready = out_free && !flush_r;
  assign gen_fire = cmd.gen && pk_ready;

  always_comb begin
    sts.col        = col_r;
    sts.past_first = past_r;
    sts.show_addr  = show_addr_r;
    sts.show_text  = show_text_r;
    sts.final_flag = fin_r;
    sts.pk_ready   = pk_ready;
  end

  // Generate one chunk of up to four characters for the current segment
  always_comb begin
    addr_w   = {line_r, 4'b0000};
    row_data = text_row_r[cmd.row];
    sp       = (col_r != hdlf_pkg::LAST_COL) || show_text_r;
    for (int i = 0; i < 4; i++) begin
      g[i] = 8'h00;
    end
    gen_n = 3'd4;
    unique case (cmd.seg)
      hdlf_pkg::SEG_NL: begin
        g[0]  = hdlf_pkg::CHAR_NL;
        gen_n = 3'd1;
      end
      hdlf_pkg::SEG_ADDR_HI: begin
        for (int i = 0; i < 4; i++) begin
          g[i] = hdlf_pkg::hex_char(addr_w[31 - 4 * i -: 4]);
        end
      end
      hdlf_pkg::SEG_ADDR_LO: begin
        for (int i = 0; i < 4; i++) begin
          g[i] = hdlf_pkg::hex_char(addr_w[15 - 4 * i -: 4]);
        end
      end
      hdlf_pkg::SEG_HEX: begin
        if (cmd.lead_space) begin
          g[0]  = hdlf_pkg::CHAR_SPACE;
          g[1]  = hdlf_pkg::hex_char(byte_r[7:4]);
          g[2]  = hdlf_pkg::hex_char(byte_r[3:0]);
          g[3]  = hdlf_pkg::CHAR_SPACE;
          gen_n = sp ? 3'd4 : 3'd3;
        end else begin
          g[0]  = hdlf_pkg::hex_char(byte_r[7:4]);
          g[1]  = hdlf_pkg::hex_char(byte_r[3:0]);
          g[2]  = hdlf_pkg::CHAR_SPACE;
          gen_n = sp ? 3'd3 : 3'd2;
        end
      end
      hdlf_pkg::SEG_PAD: begin
        for (int i = 0; i < 4; i++) begin
          g[i] = hdlf_pkg::CHAR_SPACE;
        end
        gen_n = cmd.pad_n;
      end
      hdlf_pkg::SEG_TEXT: begin
        for (int j = 0; j < 4; j++) begin
          g[j] = ({cmd.row, 2'(j)} <= col_r) ? row_data[j] : hdlf_pkg::CHAR_SPACE;
        end
      end
      default: begin
        gen_n = 3'd1;
      end
    endcase
  end

  // Join held characters with the new chunk into a seven-character window
  always_comb begin
    logic [2:0] gi;
    for (int i = 0; i < 7; i++) begin
      gi   = 3'(i) - {1'b0, hold_cnt_r};
      w[i] = 8'h00;
      if (3'(i) >= {1'b0, hold_cnt_r} && gi < 3'd4) begin
        w[i] = g[gi[1:0]];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < hold_cnt_r) begin
        w[i] = hold_r[i];
      end
    end
    tot = {1'b0, hold_cnt_r} + gen_n;
  end

  // Packer: emit full chunks, hold remainders, flush at the end of an item
  always_comb begin
    hold_nxt      = hold_r;
    hold_cnt_nxt  = hold_cnt_r;
    flush_nxt     = flush_r;
    flush_fin_nxt = flush_fin_r;
    out_load      = 1'b0;
    out_sel_cnt   = 3'd4;
    out_run_nxt   = out_run_r;
    out_dump_nxt  = out_dump_r;
    out_chr_nxt   = out_chr_r;
    if (gen_fire) begin
      if (tot >= 3'd4) begin
        out_load     = 1'b1;
        out_sel_cnt  = 3'd4;
        out_run_nxt  = cmd.last && (tot == 3'd4);
        out_dump_nxt = cmd.last && (tot == 3'd4) && fin_r;
        for (int j = 0; j < 3; j++) begin
          hold_nxt[j] = w[4 + j];
        end
        hold_cnt_nxt  = 2'(tot - 3'd4);
        flush_nxt     = cmd.last && (tot != 3'd4);
        flush_fin_nxt = fin_r;
      end else if (cmd.last) begin
        out_load     = 1'b1;
        out_sel_cnt  = tot;
        out_run_nxt  = 1'b1;
        out_dump_nxt = fin_r;
        hold_cnt_nxt = 2'd0;
      end else begin
        for (int j = 0; j < 3; j++) begin
          hold_nxt[j] = w[j];
        end
        hold_cnt_nxt = tot[1:0];
      end
    end else if (flush_r && out_free) begin
      out_load     = 1'b1;
      out_sel_cnt  = {1'b0, hold_cnt_r};
      out_run_nxt  = 1'b1;
      out_dump_nxt = flush_fin_r;
      hold_cnt_nxt = 2'd0;
      flush_nxt    = 1'b0;
    end
    // Characters beyond the count read as zero
    for (int j = 0; j < 4; j++) begin
      out_chr_nxt[j] = (3'(j) < out_sel_cnt) ? w[j] : 8'h00;
    end
    if (!out_load) begin
      out_chr_nxt = out_chr_r;
    end
    out_cnt_nxt   = out_load ? out_sel_cnt : out_cnt_r;
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  // Control registers: line state, configuration, packer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= 28'd0;
      col_r       <= 4'd0;
      past_r      <= 1'b0;
      show_addr_r <= 1'b1;
      show_text_r <= 1'b1;
      fin_r       <= 1'b0;
      hold_cnt_r  <= 2'd0;
      flush_r     <= 1'b0;
      flush_fin_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_cnt_r  <= hold_cnt_nxt;
      flush_r     <= flush_nxt;
      flush_fin_r <= flush_fin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          hdlf_pkg::REG_SHOW_ADDRESS: show_addr_r <= cfg_wdata;
          hdlf_pkg::REG_SHOW_TEXT:    show_text_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        fin_r <= in_is_final;
      end
      // Advance the line position once the item is complete
      if (gen_fire && cmd.last) begin
        if (col_r == hdlf_pkg::LAST_COL || fin_r) begin
          col_r  <= 4'd0;
          line_r <= fin_r ? 28'd0 : line_r + 28'd1;
          past_r <= !fin_r;
        end else begin
          col_r <= col_r + 4'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_data_byte;
    end
    if (gen_fire && cmd.seg == hdlf_pkg::SEG_HEX) begin
      text_row_r[col_r[3:2]][col_r[1:0]] <= hdlf_pkg::printable(byte_r);
    end
    hold_r     <= hold_nxt;
    out_chr_r  <= out_chr_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_run_r  <= out_run_nxt;
    out_dump_r <= out_dump_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char_a     = out_chr_r[0];
  assign out_char_b     = out_chr_r[1];
  assign out_char_c     = out_chr_r[2];
  assign out_char_d     = out_chr_r[3];
  assign out_char_count = out_cnt_r;
  assign out_run_end    = out_run_r;
  assign out_dump_end   = out_dump_r;

  // A pending flush always has characters to send
  a_flush_has_chars: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (hold_cnt_r != 2'd0))
    else $error("flush pending with empty hold buffer");

  // Every presented chunk carries one to four characters
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r != 3'd0 && out_cnt_r <= 3'd4))
    else $error("output chunk count out of range");

  // End of dump only ever marks the closing chunk of an item
  a_dump_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dump_r) |-> out_run_r)
    else $error("dump end without run end");

endmodule

FILE: tb/tb_hex_dump_line_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_dump_line_formatter_unit
// Self-checking bench for the hex dump line formatter. A directed table opens
// the run: address and text column options, printable-range boundaries, full
// and short lines, a new dump after the final byte and options changed
// mid-line. Random dumps follow under three sender/receiver idling mixes.
// A line model predicts every output chunk, and the bench compares each
// chunk field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_hex_dump_line_formatter_unit;

  localparam int DRAIN_CYCLES = 24;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 75;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [127:0] HEX_ASCII = "0123456789abcdef";
  localparam logic [7:0] BOUNDARY_BYTES [6] = '{8'h00, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'hff};

  // One output transaction: up to four characters plus markers
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [2:0] cnt;
    logic       run_end;
    logic       dump_end;
  } chunk_t;

  localparam chunk_t NO_CHUNK = '0;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic       reg_idx;
    logic       reg_val;
    logic [7:0] data;
    logic       fin;
    logic       typed;
    chunk_t     want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_is_final = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char_a;
  logic [7:0] out_char_b;
  logic [7:0] out_char_c;
  logic [7:0] out_char_d;
  logic [2:0] out_char_count;
  logic       out_run_end;
  logic       out_dump_end;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_wdata = 1'b0;

  hex_dump_line_formatter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_is_final    (in_is_final),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_a     (out_char_a),
    .out_char_b     (out_char_b),
    .out_char_c     (out_char_c),
    .out_char_d     (out_char_d),
    .out_char_count (out_char_count),
    .out_run_end    (out_run_end),
    .out_dump_end   (out_dump_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Line model state and option copies
  logic [27:0] line_num = '0;
  logic [3:0]  cur_col = '0;
  logic [7:0]  text_col [16] = '{default: 8'h00};
  logic        past_first = 1'b0;
  logic        m_show_addr = 1'b1;
  logic        m_show_text = 1'b1;

  chunk_t expected_chunks [$];
  chunk_t typed_chunk = NO_CHUNK;
  logic   typed_armed = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_req = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int dumps_sent = 0;
  int chunks_seen = 0;
  int idle_cycles = 0;

  // Directed table: typed chunk replaces the first predicted chunk of a row
  row_t directed_rows [29] = '{
    '{ROW_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, {"0000", 3'd4, 1'b0, 1'b0}},
    '{ROW_BYTE, 1'b0, 1'b0, 8'hff, 1'b0, 1'b1, {"ff ", 8'h00, 3'd3, 1'b1, 1'b0}},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h1f, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h20, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h7e, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h7f, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h41, 1'b1, 1'b0, NO_CHUNK},
    '{ROW_CFG, hdlf_pkg::REG_SHOW_TEXT, 1'b0, 8'h00, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h5a, 1'b1, 1'b1, {"0000", 3'd4, 1'b0, 1'b0}},
    '{ROW_CFG, hdlf_pkg::REG_SHOW_ADDRESS, 1'b0, 8'h00, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'ha5, 1'b0, 1'b1, {"a5 ", 8'h00, 3'd3, 1'b1, 1'b0}},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h01, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h0f, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h10, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h1f, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h20, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h2e, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h30, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h39, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h61, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h7e, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h7f, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h80, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'hfe, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_CFG, hdlf_pkg::REG_SHOW_TEXT, 1'b1, 8'h00, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'hff, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_CFG, hdlf_pkg::REG_SHOW_ADDRESS, 1'b1, 8'h00, 1'b0, 1'b0, NO_CHUNK},
    '{ROW_BYTE, 1'b0, 1'b0, 8'h80, 1'b1, 1'b1, {8'h0a, "000", 3'd4, 1'b0, 1'b0}}
  };

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    return HEX_ASCII[8 * (15 - n) +: 8];
  endfunction

  // Advance the line model by one byte and queue the chunks it produces
  function automatic void predict_dump_text(input logic [7:0] d, input logic fin);
    logic [7:0] line_chars [$];
    logic [31:0] addr;
    logic [3:0] c;
    chunk_t ck;
    int i, n, base, cnt;
    c = cur_col;
    if (c == 4'd0) begin
      if (past_first) line_chars.push_back(hdlf_pkg::CHAR_NL);
      if (m_show_addr) begin
        addr = {line_num, 4'h0};
        for (i = 7; i >= 0; i--) line_chars.push_back(nib_char(addr[4 * i +: 4]));
        line_chars.push_back(hdlf_pkg::CHAR_SPACE);
      end
    end
    line_chars.push_back(nib_char(d[7:4]));
    line_chars.push_back(nib_char(d[3:0]));
    if (c != hdlf_pkg::LAST_COL || m_show_text) line_chars.push_back(hdlf_pkg::CHAR_SPACE);
    text_col[c] = (d >= hdlf_pkg::CHAR_SPACE && d <= hdlf_pkg::CHAR_TILDE) ?
                  d : hdlf_pkg::CHAR_DOT;
    if (c == hdlf_pkg::LAST_COL || fin) begin
      // pad the hex part, then flush the text column
      for (i = int'(c) + 1; i <= 15; i++) begin
        line_chars.push_back(hdlf_pkg::CHAR_SPACE);
        line_chars.push_back(hdlf_pkg::CHAR_SPACE);
        if (i != 15 || m_show_text) line_chars.push_back(hdlf_pkg::CHAR_SPACE);
      end
      if (m_show_text) begin
        for (i = 0; i <= 15; i++) begin
          line_chars.push_back(i <= int'(c) ? text_col[i] : hdlf_pkg::CHAR_SPACE);
        end
      end
      cur_col = 4'd0;
      line_num = line_num + 28'd1;
      past_first = 1'b1;
      if (fin) begin
        line_num = '0;
        past_first = 1'b0;
      end
    end else begin
      cur_col = c + 4'd1;
    end
    // pack four characters per chunk, zero beyond the count
    n = line_chars.size();
    for (base = 0; base < n; base += 4) begin
      cnt = (n - base > 4) ? 4 : n - base;
      ck.a = line_chars[base];
      ck.b = (cnt > 1) ? line_chars[base + 1] : 8'h00;
      ck.c = (cnt > 2) ? line_chars[base + 2] : 8'h00;
      ck.d = (cnt > 3) ? line_chars[base + 3] : 8'h00;
      ck.cnt = 3'(cnt);
      ck.run_end = (base + 4 >= n);
      ck.dump_end = (base + 4 >= n) && fin;
      expected_chunks.push_back(ck);
    end
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Predict on each input transaction, then check each output transaction
  always @(posedge clk) begin : chunk_check
    int base;
    chunk_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        base = expected_chunks.size();
        predict_dump_text(in_data_byte, in_is_final);
        if (typed_armed) begin
          expected_chunks[base] = typed_chunk;
          typed_armed = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        chunks_seen++;
        if (expected_chunks.size() == 0) begin
          $display("%0t ns: unexpected chunk, expected none, got %h %h %h %h count %0d",
                   $time, out_char_a, out_char_b, out_char_c, out_char_d, out_char_count);
          mismatches++;
        end else begin
          want = expected_chunks.pop_front();
          check_field("char_a", want.a, out_char_a);
          check_field("char_b", want.b, out_char_b);
          check_field("char_c", want.c, out_char_c);
          check_field("char_d", want.d, out_char_d);
          check_field("char_count", 8'(want.cnt), 8'(out_char_count));
          check_field("run_end", 8'(want.run_end), 8'(out_run_end));
          check_field("dump_end", 8'(want.dump_end), 8'(out_dump_end));
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: stop when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one byte, idling first at random; hold it until accepted
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_is_final <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (fin) dumps_sent++;
  endtask

  // Stop sending and let every expected chunk arrive
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one option, then leave a falling edge with the write enable low
  task automatic write_reg(input logic idx, input logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == hdlf_pkg::REG_SHOW_ADDRESS) m_show_addr = val;
    else m_show_text = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random dumps of mostly short length, options changed between and within
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input bit squeeze);
    int sent, len, i;
    logic [7:0] b;
    sent = 0;
    wait_for_drain();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (squeeze) long_hold_req = 1'b1;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(1) == 1) begin
        wait_for_drain();
        write_reg(hdlf_pkg::REG_SHOW_ADDRESS, 1'($urandom_range(1)));
        write_reg(hdlf_pkg::REG_SHOW_TEXT, 1'($urandom_range(1)));
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(70, 33) : $urandom_range(20, 1);
      for (i = 0; i < len; i++) begin
        if (i != 0 && $urandom_range(15) == 0) begin
          wait_for_drain();
          if ($urandom_range(1) == 1) write_reg(hdlf_pkg::REG_SHOW_ADDRESS, ~m_show_addr);
          else write_reg(hdlf_pkg::REG_SHOW_TEXT, ~m_show_text);
        end
        b = ($urandom_range(3) == 0) ? BOUNDARY_BYTES[$urandom_range(5)] : 8'($urandom);
        send_byte(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    send_idle_pct = 30;
    recv_stall_pct = 80;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_for_drain();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        typed_chunk = directed_rows[r].want;
        typed_armed = directed_rows[r].typed;
        send_byte(directed_rows[r].data, directed_rows[r].fin);
      end
    end

    // Random dumps: receiver-heavy idling, sender-heavy idling, then none with a long hold-off
    run_random_phase(30, 80, 1'b0);
    run_random_phase(80, 30, 1'b0);
    run_random_phase(0, 0, 1'b1);
    wait_for_drain();

    $display("Run covered %0d bytes in %0d dumps and %0d output chunks,", bytes_sent,
             dumps_sent, chunks_seen);
    $display("with all option settings, mid-line option changes and a long output hold-off.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
